// ----- hdl/ppp_pkg.sv -----
package ppp_pkg;

   localparam int CW     = 32;          // coordinate width
   localparam int LW     = 16;          // near-zero limit width
   localparam int EW     = CW + 1;      // point minus eye
   localparam int PW     = 2 * CW + 1;  // normal times difference
   localparam int NCW    = 2 * CW;      // normal times eye
   localparam int DW     = PW + 1;      // denominator and distance
   localparam int HW     = PW - EW;     // upper slice of distance magnitude
   localparam int MW     = PW + EW;     // numerator magnitude
   localparam int QB     = 34;          // quotient bits resolved before saturation
   localparam int RW     = DW + 1;      // partial remainder
   localparam int QW     = QB + 2;      // signed quotient
   localparam int SW     = QW + 1;      // quotient plus eye
   localparam int NAXES  = 3;
   localparam int QDEPTH = 4;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int AW     = 5;
   localparam int IW     = 3;

   localparam logic [IW-1:0] REG_NORMAL_X = 3'd0;
   localparam logic [IW-1:0] REG_NORMAL_Y = 3'd1;
   localparam logic [IW-1:0] REG_NORMAL_Z = 3'd2;
   localparam logic [IW-1:0] REG_OFFSET   = 3'd3;
   localparam logic [IW-1:0] REG_EYE_X    = 3'd4;
   localparam logic [IW-1:0] REG_EYE_Y    = 3'd5;
   localparam logic [IW-1:0] REG_EYE_Z    = 3'd6;
   localparam logic [IW-1:0] REG_LIMIT    = 3'd7;

   localparam logic [CW-1:0] NORMAL_Z_RESET = 32'h0001_0000;
   localparam logic [LW-1:0] LIMIT_RESET    = 16'd1;

   typedef struct packed {
      logic [NAXES-1:0][CW-1:0] normal;
      logic [CW-1:0]            offset;
      logic [NAXES-1:0][CW-1:0] eye;
      logic [LW-1:0]            limit;
   } ppp_cfg_type;

   typedef struct packed {
      logic                     ok;
      logic [DW-1:0]            denom;
      logic [DW-1:0]            pdist;
      logic [NAXES-1:0][EW-1:0] diff;
   } ppp_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } ppp_qctl_type;

endpackage

// ----- hdl/ppp_req_if.sv -----
interface ppp_req_if import ppp_pkg::*; ();
   logic          valid;
   logic          ready;
   logic [CW-1:0] point_x;
   logic [CW-1:0] point_y;
   logic [CW-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z, input ready);
   modport sink (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

// ----- hdl/ppp_rsp_if.sv -----
interface ppp_rsp_if import ppp_pkg::*; ();
   logic          valid;
   logic          ready;
   logic          valid_res;
   logic [CW-1:0] proj_x;
   logic [CW-1:0] proj_y;
   logic [CW-1:0] proj_z;

   modport source (output valid, output valid_res, output proj_x, output proj_y, output proj_z,
                   input ready);
   modport sink (input valid, input valid_res, input proj_x, input proj_y, input proj_z,
                 output ready);
endinterface

// ----- hdl/perspective_point_to_plane.sv -----
// Central projection of points onto the plane n.X = d0 as seen from the eye C, all values
// signed fixed point with FRAC_BITS fraction bits. One item is accepted per clock while the
// result side keeps up; most of the path is the 34-stage restoring divider (one quotient
// bit per stage, three lanes). The front computes the denominator, the plane distance and
// the near-zero test, and hands items to a 4-entry queue; the back stalls on its own when
// the result is not taken, and the front keeps accepting until the queue fills. Items whose
// denominator is at or below the limit come out with valid_res low and zero coordinates.
// Write registers only while idle.
module perspective_point_to_plane import ppp_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   ppp_req_if.sink       req_chan,
   ppp_rsp_if.source     rsp_chan,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [AW-1:0] csr_paddr,
   input  logic [CW-1:0] csr_pwdata,
   output logic [CW-1:0] csr_prdata,
   output logic          csr_pready
);

   ppp_cfg_type   cfg;
   ppp_entry_type wentry, rentry;
   ppp_qctl_type  qstat;
   logic          push, pop;

   ppp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ppp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .cfg    (cfg),
      .q_full (qstat.full),
      .push   (push),
      .entry  (wentry)
   );

   ppp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .wdata (wentry),
      .rdata (rentry),
      .push  (push),
      .pop   (pop),
      .stat  (qstat)
   );

   ppp_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .head    (rentry),
      .q_empty (qstat.empty),
      .pop     (pop),
      .rsp     (rsp_chan)
   );

endmodule

// ----- hdl/ppp_csr.sv -----
module ppp_csr import ppp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [AW-1:0] csr_paddr,
   input  logic [CW-1:0] csr_pwdata,
   output logic [CW-1:0] csr_prdata,
   output logic          csr_pready,
   output ppp_cfg_type   cfg
);

   ppp_cfg_type   cfg_ff, cfg_in;
   logic [IW-1:0] idx;
   logic          wr;

   assign idx        = csr_paddr[AW-1:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_NORMAL_X: cfg_in.normal[0] = csr_pwdata;
            REG_NORMAL_Y: cfg_in.normal[1] = csr_pwdata;
            REG_NORMAL_Z: cfg_in.normal[2] = csr_pwdata;
            REG_OFFSET:   cfg_in.offset    = csr_pwdata;
            REG_EYE_X:    cfg_in.eye[0]    = csr_pwdata;
            REG_EYE_Y:    cfg_in.eye[1]    = csr_pwdata;
            REG_EYE_Z:    cfg_in.eye[2]    = csr_pwdata;
            REG_LIMIT:    cfg_in.limit     = csr_pwdata[LW-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_NORMAL_X: csr_prdata = cfg_ff.normal[0];
         REG_NORMAL_Y: csr_prdata = cfg_ff.normal[1];
         REG_NORMAL_Z: csr_prdata = cfg_ff.normal[2];
         REG_OFFSET:   csr_prdata = cfg_ff.offset;
         REG_EYE_X:    csr_prdata = cfg_ff.eye[0];
         REG_EYE_Y:    csr_prdata = cfg_ff.eye[1];
         REG_EYE_Z:    csr_prdata = cfg_ff.eye[2];
         REG_LIMIT:    csr_prdata = CW'(cfg_ff.limit);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{normal: {NORMAL_Z_RESET, {(2*CW){1'b0}}}, offset: '0, eye: '0,
                     limit: LIMIT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hdl/ppp_front.sv -----
module ppp_front import ppp_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   ppp_req_if.sink       req,
   input  ppp_cfg_type   cfg,
   input  logic          q_full,
   output logic          push,
   output ppp_entry_type entry
);

   logic                  fe;
   logic [CW-1:0]         pt [NAXES];
   logic signed [EW-1:0]  diff_w [NAXES];
   logic                  v1_ff, v2_ff;
   logic signed [EW-1:0]  diff1_ff [NAXES];
   logic signed [EW-1:0]  diff2_ff [NAXES];
   logic signed [PW-1:0]  nd_in [NAXES];
   logic signed [PW-1:0]  nd2_ff [NAXES];
   logic signed [NCW-1:0] nc_in [NAXES];
   logic signed [NCW-1:0] nc2_ff [NAXES];
   logic signed [DW-1:0]  denom_w, nc_w, dist_w, lim_w;

   assign fe        = !q_full;
   assign req.ready = fe;
   assign push      = v2_ff && fe;
   assign pt[0]     = req.point_x;
   assign pt[1]     = req.point_y;
   assign pt[2]     = req.point_z;

   always_comb begin
      for (int i = 0; i < NAXES; i++) begin
         diff_w[i] = EW'($signed(pt[i])) - EW'($signed(cfg.eye[i]));
         nd_in[i]  = $signed(cfg.normal[i]) * diff1_ff[i];
         nc_in[i]  = $signed(cfg.normal[i]) * $signed(cfg.eye[i]);
      end
   end

   // denominator, distance of the plane from the eye, and the near-zero test
   always_comb begin
      denom_w = DW'(nd2_ff[0]) + DW'(nd2_ff[1]) + DW'(nd2_ff[2]);
      nc_w    = DW'(nc2_ff[0]) + DW'(nc2_ff[1]) + DW'(nc2_ff[2]);
      dist_w  = (DW'($signed(cfg.offset)) <<< FRAC_BITS) - nc_w;
      lim_w   = $signed(DW'(cfg.limit) << FRAC_BITS);
      entry.ok    = denom_w > lim_w;
      entry.denom = denom_w;
      entry.pdist = dist_w;
      for (int i = 0; i < NAXES; i++) begin
         entry.diff[i] = diff2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (fe) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fe) begin
         for (int i = 0; i < NAXES; i++) begin
            diff1_ff[i] <= diff_w[i];
            diff2_ff[i] <= diff1_ff[i];
            nd2_ff[i]   <= nd_in[i];
            nc2_ff[i]   <= nc_in[i];
         end
      end
   end

endmodule

// ----- hdl/ppp_queue.sv -----
module ppp_queue import ppp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ppp_entry_type wdata,
   output ppp_entry_type rdata,
   input  logic          push,
   input  logic          pop,
   output ppp_qctl_type  stat
);

   ppp_entry_type  mem_ff [QDEPTH];
   logic [QPW-1:0] wp_ff, rp_ff;
   logic [QPW:0]   cnt_ff, cnt_in;

   assign rdata      = mem_ff[rp_ff];
   assign stat.push  = push;
   assign stat.pop   = pop;
   assign stat.full  = cnt_ff == (QPW+1)'(QDEPTH);
   assign stat.empty = cnt_ff == '0;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && stat.full)) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && stat.empty)) else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPW+1)'(QDEPTH)) else $error("queue count out of range");
`endif

endmodule

// ----- hdl/ppp_back.sv -----
module ppp_back import ppp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ppp_cfg_type   cfg,
   input  ppp_entry_type head,
   input  logic          q_empty,
   output logic          pop,
   ppp_rsp_if.source     rsp
);

   logic be;

   // s0: magnitudes and signs
   logic                v0_ff, ok0_ff;
   logic [DW-1:0]       den0_ff;
   logic [PW-1:0]       dmag0_ff;
   logic [EW-1:0]       emag0_ff [NAXES];
   logic                neg0_ff [NAXES];
   logic signed [DW-1:0] dist_s, dist_abs;
   logic signed [EW-1:0] diff_s [NAXES];
   logic signed [EW-1:0] diff_abs [NAXES];

   // s1: partial products, s2: numerator magnitude
   logic                v1_ff, ok1_ff, v2_ff, ok2_ff;
   logic [DW-1:0]       den1_ff, den2_ff;
   logic                neg1_ff [NAXES];
   logic                neg2_ff [NAXES];
   logic [2*EW-1:0]     plo1_ff [NAXES];
   logic [HW+EW-1:0]    phi1_ff [NAXES];
   logic [MW-1:0]       mag2_ff [NAXES];

   // divider stages, shared sideband
   logic                vd_ff [QB+1];
   logic                okd_ff [QB+1];
   logic [DW-1:0]       dend_ff [QB+1];

   logic                out_v_ff, out_ok_ff;
   logic [CW-1:0]       out_p_ff [NAXES];
   logic [CW-1:0]       res_w [NAXES];

   assign be  = !out_v_ff || rsp.ready;
   assign pop = be && !q_empty;

   always_comb begin
      dist_s   = $signed(head.pdist);
      dist_abs = dist_s[DW-1] ? -dist_s : dist_s;
      for (int i = 0; i < NAXES; i++) begin
         diff_s[i]   = $signed(head.diff[i]);
         diff_abs[i] = diff_s[i][EW-1] ? -diff_s[i] : diff_s[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         out_v_ff <= 1'b0;
         for (int j = 0; j <= QB; j++) begin
            vd_ff[j] <= 1'b0;
         end
      end else if (be) begin
         v0_ff    <= !q_empty;
         v1_ff    <= v0_ff;
         v2_ff    <= v1_ff;
         vd_ff[0] <= v2_ff;
         for (int j = 1; j <= QB; j++) begin
            vd_ff[j] <= vd_ff[j-1];
         end
         out_v_ff <= vd_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (be) begin
         ok0_ff   <= head.ok;
         den0_ff  <= head.denom;
         dmag0_ff <= dist_abs[PW-1:0];
         ok1_ff   <= ok0_ff;
         den1_ff  <= den0_ff;
         ok2_ff   <= ok1_ff;
         den2_ff  <= den1_ff;
         okd_ff[0]  <= ok2_ff;
         dend_ff[0] <= den2_ff;
         for (int j = 1; j <= QB; j++) begin
            okd_ff[j]  <= okd_ff[j-1];
            dend_ff[j] <= dend_ff[j-1];
         end
         for (int i = 0; i < NAXES; i++) begin
            emag0_ff[i] <= diff_abs[i];
            neg0_ff[i]  <= dist_s[DW-1] ^ diff_s[i][EW-1];
            neg1_ff[i]  <= neg0_ff[i];
            neg2_ff[i]  <= neg1_ff[i];
            plo1_ff[i]  <= dmag0_ff[EW-1:0] * emag0_ff[i];
            phi1_ff[i]  <= dmag0_ff[PW-1:EW] * emag0_ff[i];
            mag2_ff[i]  <= {phi1_ff[i], {EW{1'b0}}} + MW'(plo1_ff[i]);
         end
         out_ok_ff <= okd_ff[QB];
         for (int i = 0; i < NAXES; i++) begin
            out_p_ff[i] <= okd_ff[QB] ? res_w[i] : '0;
         end
      end
   end

   for (genvar l = 0; l < NAXES; l++) begin : g_lane
      logic [RW-1:0]        rem_ff [QB+1];
      logic [QB-1:0]        quo_ff [QB+1];
      logic [QB-1:0]        low_ff [QB+1];
      logic                 neg_ff [QB+1];
      logic                 big_ff [QB+1];
      logic [RW-1:0]        rsh [QB+1];
      logic                 ge [QB+1];
      logic [QW-1:0]        qe, qs;
      logic signed [SW-1:0] sum;
      logic                 remnz, ovf;

      // restoring division, one quotient bit per stage
      always_comb begin
         rsh[0] = '0;
         ge[0]  = 1'b0;
         for (int j = 1; j <= QB; j++) begin
            rsh[j] = {rem_ff[j-1][RW-2:0], low_ff[j-1][QB-1]};
            ge[j]  = rsh[j] >= {1'b0, dend_ff[j-1]};
         end
      end

      always_ff @(posedge clock) begin
         if (be) begin
            // quotient too large for any representable result
            big_ff[0] <= {2'b00, mag2_ff[l]} >= {den2_ff, {QB{1'b0}}};
            neg_ff[0] <= neg2_ff[l];
            rem_ff[0] <= RW'(mag2_ff[l][MW-1:QB]);
            low_ff[0] <= mag2_ff[l][QB-1:0];
            quo_ff[0] <= '0;
            for (int j = 1; j <= QB; j++) begin
               big_ff[j] <= big_ff[j-1];
               neg_ff[j] <= neg_ff[j-1];
               rem_ff[j] <= ge[j] ? rsh[j] - {1'b0, dend_ff[j-1]} : rsh[j];
               quo_ff[j] <= {quo_ff[j-1][QB-2:0], ge[j]};
               low_ff[j] <= {low_ff[j-1][QB-2:0], 1'b0};
            end
         end
      end

      // floor for negative quotients, add the eye, saturate
      always_comb begin
         remnz = rem_ff[QB] != '0;
         qe    = {2'b00, quo_ff[QB]};
         qs    = neg_ff[QB] ? (QW'(0) - qe - QW'(remnz)) : qe;
         sum   = SW'($signed(qs)) + SW'($signed(cfg.eye[l]));
         ovf   = sum[SW-1:CW-1] != '0 && sum[SW-1:CW-1] != '1;
         if (big_ff[QB]) begin
            res_w[l] = neg_ff[QB] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end else if (ovf) begin
            res_w[l] = sum[SW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
         end else begin
            res_w[l] = sum[CW-1:0];
         end
      end
   end

   assign rsp.valid     = out_v_ff;
   assign rsp.valid_res = out_ok_ff;
   assign rsp.proj_x    = out_p_ff[0];
   assign rsp.proj_y    = out_p_ff[1];
   assign rsp.proj_z    = out_p_ff[2];

`ifndef SYNTH
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !out_ok_ff) |-> (out_p_ff[0] == '0 && out_p_ff[1] == '0 &&
      out_p_ff[2] == '0)) else $error("invalid item carries nonzero coordinates");
   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> v0_ff) else $error("popped item lost at first back stage");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !be |=> ($stable(vd_ff[QB]) && $stable(v0_ff))) else $error("pipeline moved while stalled");
`endif

endmodule

// ----- test/tb_perspective_point_to_plane.sv -----
`timescale 1ns / 1ps

module tb_perspective_point_to_plane;
   import ppp_pkg::*;

   localparam int FRAC = 16;
   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int N_RANDOM = 1400;

   typedef struct packed {
      logic [CW-1:0] px;
      logic [CW-1:0] py;
      logic [CW-1:0] pz;
   } point_t;

   typedef struct packed {
      logic          ok;
      logic [CW-1:0] qx;
      logic [CW-1:0] qy;
      logic [CW-1:0] qz;
   } proj_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [AW-1:0] csr_paddr = '0;
   logic [CW-1:0] csr_pwdata = '0;
   logic [CW-1:0] csr_prdata;
   logic csr_pready;

   ppp_req_if req_chan ();
   ppp_rsp_if rsp_chan ();

   perspective_point_to_plane #(.FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the plane setup
   logic signed [CW-1:0] nrm [NAXES];
   logic signed [CW-1:0] plane_d0;
   logic signed [CW-1:0] eye [NAXES];
   logic [LW-1:0]        near_lim;

   point_t pending_points[$];
   proj_t  expected_proj[$];
   int     errors = 0;
   int     cycles = 0;
   bit     calm = 0;        // no idling in the final stretch
   int     req_gap = 0, rsp_gap = 0;

   function automatic proj_t project_point(point_t p);
      logic signed [CW-1:0] pt [NAXES];
      logic signed [127:0] denom, nc, pdist, num, q, r, s, lim;
      logic signed [127:0] df [NAXES];
      proj_t res;
      pt[0] = p.px; pt[1] = p.py; pt[2] = p.pz;
      denom = 0; nc = 0;
      for (int i = 0; i < NAXES; i++) begin
         df[i] = 128'(pt[i]) - 128'(eye[i]);
         denom += 128'(nrm[i]) * df[i];
         nc += 128'(nrm[i]) * 128'(eye[i]);
      end
      pdist = (128'(plane_d0) <<< FRAC) - nc;
      lim = 128'(signed'({1'b0, near_lim})) <<< FRAC;
      res = '0;
      if (denom <= lim) return res;
      res.ok = 1'b1;
      for (int i = 0; i < NAXES; i++) begin
         num = pdist * df[i];
         q = num / denom;
         r = num % denom;
         if (r != 0 && num < 0) q -= 1;   // floor division
         s = q + 128'(eye[i]);
         if (s > 128'sd2147483647) s = 128'sd2147483647;
         else if (s < -128'sd2147483648) s = -128'sd2147483648;
         case (i)
            0: res.qx = s[CW-1:0];
            1: res.qy = s[CW-1:0];
            default: res.qz = s[CW-1:0];
         endcase
      end
      return res;
   endfunction

   task automatic write_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= AW'(idx) << 2; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         REG_NORMAL_X: nrm[0] = val;
         REG_NORMAL_Y: nrm[1] = val;
         REG_NORMAL_Z: nrm[2] = val;
         REG_OFFSET:   plane_d0 = val;
         REG_EYE_X:    eye[0] = val;
         REG_EYE_Y:    eye[1] = val;
         REG_EYE_Z:    eye[2] = val;
         REG_LIMIT:    near_lim = val[LW-1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_points.size() != 0 || expected_proj.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic logic [CW-1:0] rand_coord(int scale);
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return CW'(int'($urandom_range(0, 2 * scale)) - scale) <<< 16;
      endcase
   endfunction

   task automatic random_setup(bit extreme);
      write_reg(REG_NORMAL_X, extreme ? 32'h8000_0000 : rand_coord(4));
      write_reg(REG_NORMAL_Y, extreme ? 32'h7FFF_FFFF : rand_coord(4));
      write_reg(REG_NORMAL_Z, extreme ? 32'h7FFF_FFFF : rand_coord(4));
      write_reg(REG_OFFSET, rand_coord(50));
      write_reg(REG_EYE_X, rand_coord(50));
      write_reg(REG_EYE_Y, rand_coord(50));
      write_reg(REG_EYE_Z, extreme ? 32'h8000_0000 : rand_coord(50));
      write_reg(REG_LIMIT, extreme ? 32'h0000_FFFF : CW'($urandom_range(0, 3)));
   endtask

   function automatic point_t rand_point();
      point_t p;
      p.px = rand_coord(100); p.py = rand_coord(100); p.pz = rand_coord(100);
      return p;
   endfunction

   // driver; the item on the bus stays at the head of the queue until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap <= 0;
      end else if (req_chan.valid && !req_chan.ready) begin
         // hold
      end else begin
         if (req_chan.valid) expected_proj.push_back(project_point(pending_points.pop_front()));
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            req_gap <= $urandom_range(1, 13) - 1;
            req_chan.valid <= 1'b0;
         end else if (pending_points.size() != 0) begin
            point_t p;
            p = pending_points[0];
            req_chan.valid <= 1'b1;
            req_chan.point_x <= p.px; req_chan.point_y <= p.py; req_chan.point_z <= p.pz;
         end else
            req_chan.valid <= 1'b0;
      end
   end

   // monitor and result side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_proj.size() == 0) begin
               $error("unexpected item");
               errors++;
            end else begin
               proj_t e;
               e = expected_proj.pop_front();
               if (rsp_chan.valid_res !== e.ok) begin
                  $error("valid_res exp %0b got %0b", e.ok, rsp_chan.valid_res); errors++;
               end
               if (rsp_chan.proj_x !== e.qx) begin
                  $error("proj_x exp %h got %h", e.qx, rsp_chan.proj_x); errors++;
               end
               if (rsp_chan.proj_y !== e.qy) begin
                  $error("proj_y exp %h got %h", e.qy, rsp_chan.proj_y); errors++;
               end
               if (rsp_chan.proj_z !== e.qz) begin
                  $error("proj_z exp %h got %h", e.qz, rsp_chan.proj_z); errors++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 12) == 0) begin
            rsp_gap <= $urandom_range(1, 13) - 1;
            rsp_chan.ready <= 1'b0;
         end else
            rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("perspective_point_to_plane: mismatch");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.point_x = '0; req_chan.point_y = '0; req_chan.point_z = '0;
      rsp_chan.ready = 1'b0;
      nrm[0] = '0; nrm[1] = '0; nrm[2] = NORMAL_Z_RESET;
      plane_d0 = '0; eye[0] = '0; eye[1] = '0; eye[2] = '0;
      near_lim = LIMIT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, reset setup: plane z=0, eye at origin gives denom = pz
      pending_points.push_back('{32'h0001_0000, 32'h0002_0000, 32'h0003_0000});
      pending_points.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
      pending_points.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
      pending_points.push_back('{32'h0, 32'h0, 32'h0});           // zero denominator
      pending_points.push_back('{32'h5, 32'h5, 32'h0001_0000});   // denom of one, above the limit
      pending_points.push_back('{32'h5, 32'h5, 32'h0001_0001});   // just above a denom of one
      pending_points.push_back('{32'h5, 32'h5, 32'hFFFF_0000});   // behind the eye
      drain();

      write_reg(REG_OFFSET, 32'h0005_0000);
      write_reg(REG_EYE_Z, 32'hFFF6_0000);
      write_reg(REG_EYE_X, 32'h0003_8000);
      pending_points.push_back('{32'hFFFF_FFFF, 32'h0001_0000, 32'h0000_0001});
      pending_points.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFF7_0000});
      pending_points.push_back('{32'h1234_5678, 32'h8765_4321, 32'h0010_0000});
      drain();

      // extreme setup
      random_setup(1'b1);
      for (int i = 0; i < 12; i++) pending_points.push_back(rand_point());
      drain();
      write_reg(REG_LIMIT, 32'h0);
      write_reg(REG_NORMAL_X, 32'h0); write_reg(REG_NORMAL_Y, 32'h0);
      write_reg(REG_NORMAL_Z, 32'h0);
      for (int i = 0; i < 4; i++) pending_points.push_back(rand_point());
      drain();

      for (int ph = 0; ph < 14; ph++) begin
         random_setup(ph == 7);
         if (ph == 13) calm = 1;
         for (int i = 0; i < N_RANDOM / 14; i++) pending_points.push_back(rand_point());
         drain();  // sender holds until all results are back
      end

      if (errors == 0)
         $display("perspective_point_to_plane: match");
      else
         $display("perspective_point_to_plane: mismatch");
      $finish;
   end
endmodule
